FILE: rtl/core/fst_pkg.sv
package fst_pkg;

   // input word kinds
   localparam logic [1:0] KIND_WINDOW = 2'd0;
   localparam logic [1:0] KIND_DATA   = 2'd1;
   localparam logic [1:0] KIND_REDUND = 2'd2;
   localparam logic [1:0] KIND_RESET  = 2'd3;

   // tag types
   localparam logic [1:0] TAG_NONE   = 2'd0;
   localparam logic [1:0] TAG_NEW    = 2'd1;
   localparam logic [1:0] TAG_REDUND = 2'd2;
   localparam logic [1:0] TAG_RETX   = 2'd3;

   // register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_DYNAMIC = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTSIDE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUPS  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SEGMENT = 3'd5;
   localparam int unsigned CSR_DATA_W = 16;

   // divider
   localparam int unsigned DIV_W = 32;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV1,
      ST_EVAL,
      ST_DIV2,
      ST_CLAMP,
      ST_MUL,
      ST_DONE
   } fst_state_type;

endpackage

FILE: rtl/core/fst_div.sv
module fst_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [fst_pkg::DIV_W-1:0] dividend,
   input  logic [fst_pkg::DIV_W-1:0] divisor,
   output logic [fst_pkg::DIV_W-1:0] quotient,
   output fst_pkg::div_stat_type     stat
);
   import fst_pkg::*;

   // restoring divider, one quotient bit a cycle
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [DIV_W:0] shifted;
   logic [DIV_W:0] diff;
   logic           ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = shifted >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

FILE: rtl/core/fec_sender_tagger.sv
// FEC sender tagger.
// Request channel (req_): one word per item, kind selects window update,
// data packet, redundancy packet or round reset. Response channel (rsp_):
// exactly one word per request word, in order, carrying the tag fields,
// the current FEC window and the clamp flag.
// Data, redundancy and round reset words are handled in the accept cycle;
// the response is registered and shows in the cycle after acceptance.
// A window update runs cwnd_bytes / segment_size on the shared divider
// (one quotient bit a cycle), then evaluates the packet window. Static
// mode, and dynamic inner mode below base window * groups + groups, give
// the response from there. Otherwise dynamic mode uses the divider a
// second time for the per-group window, then clamps and multiplies.
// The sequencer takes one word at a time; req_ready is low while a window
// update is being worked. A finished response waits in the output
// register; the next word is still taken while it waits, provided it is
// taken out by the receiver in the same cycle or it has already gone.
// A stalled receiver therefore holds the block after one pending word.
// Configuration is written through csr_we / csr_index / csr_wdata by the
// user, only while idle; the block does not enforce it. Synchronous reset
// sets group count 1, segment size 1000, round 1, other control state zero.
module fec_sender_tagger (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_kind,
   input  logic [31:0]                      req_cwnd_bytes,
   input  logic [31:0]                      req_seq,
   input  logic [31:0]                      req_high_tx_mark,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_tagged_res,
   output logic [1:0]                       rsp_tag_type,
   output logic [31:0]                      rsp_tag_serial,
   output logic [31:0]                      rsp_tag_round,
   output logic [7:0]                       rsp_tag_group,
   output logic [7:0]                       rsp_tag_groups,
   output logic [31:0]                      rsp_fec_window,
   output logic                             rsp_clamp_hit,
   input  logic                             csr_we,
   input  logic [fst_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fst_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import fst_pkg::*;

   // config registers
   logic        dynamic_ff, dynamic_in;
   logic        outside_ff, outside_in;
   logic [15:0] base_ff, base_in;
   logic [15:0] max_ff, max_in;
   logic [7:0]  gcfg_ff, gcfg_in;
   logic [15:0] seg_ff, seg_in;

   // tagging state
   logic [31:0] round_ff, round_in;
   logic [7:0]  group_ff, group_in;
   logic [31:0] serial_ff, serial_in;
   logic [7:0]  active_ff, active_in;
   logic [31:0] window_ff, window_in;

   // window update working registers
   logic [23:0] full_ff, full_in;     // base_window * groups
   logic [7:0]  geff_ff, geff_in;
   logic [31:0] win_ff, win_in;       // window in packets
   logic [31:0] fc_ff, fc_in;         // per-group window
   logic [7:0]  n_ff, n_in;
   logic        clamp_ff, clamp_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        tagged_ff, tagged_in;
   logic [1:0]  ttype_ff, ttype_in;
   logic [31:0] tserial_ff, tserial_in;
   logic [31:0] tround_ff, tround_in;
   logic [7:0]  tgroup_ff, tgroup_in;
   logic [7:0]  tgroups_ff, tgroups_in;
   logic [31:0] rwin_ff, rwin_in;
   logic        rclamp_ff, rclamp_in;

   fst_state_type state_ff, state_in;

   // shared divider
   logic               div_start;
   logic [DIV_W-1:0]   div_dividend;
   logic [DIV_W-1:0]   div_divisor;
   logic [DIV_W-1:0]   div_quotient;
   div_stat_type       div_stat;

   fst_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .stat     (div_stat)
   );

   logic        out_free;
   logic        accept;
   logic [7:0]  g_eff;
   logic [15:0] seg_eff;
   logic [24:0] win_edge;
   logic        win_ge_edge;
   logic        win_lt_g;
   logic [31:0] seq_diff;
   logic [7:0]  grp_cur;
   logic [7:0]  grp_inc;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign accept      = req_valid && req_ready;
   assign g_eff       = (gcfg_ff == 8'd0) ? 8'd1 : gcfg_ff;
   assign seg_eff     = (seg_ff == 16'd0) ? 16'd1 : seg_ff;
   assign win_edge    = {1'b0, full_ff} + {17'd0, geff_ff};
   assign win_ge_edge = win_ff >= {7'd0, win_edge};
   assign win_lt_g    = win_ff < {24'd0, geff_ff};
   assign seq_diff    = req_seq - req_high_tx_mark;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_kind == KIND_WINDOW) state_in = ST_DIV1;
         end
         ST_DIV1: begin
            if (div_stat.done) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (!dynamic_ff || (!outside_ff && !win_ge_edge)) state_in = ST_DONE;
            else state_in = ST_DIV2;
         end
         ST_DIV2: begin
            if (div_stat.done) state_in = ST_CLAMP;
         end
         ST_CLAMP: state_in = ST_MUL;
         ST_MUL:   state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready    = 1'b0;
      div_start    = 1'b0;
      div_dividend = req_cwnd_bytes;
      div_divisor  = {16'd0, seg_eff};
      case (state_ff)
         ST_IDLE: begin
            req_ready = out_free;
            div_start = accept && req_kind == KIND_WINDOW;
         end
         ST_EVAL: begin
            div_start = dynamic_ff && (outside_ff || win_ge_edge);
            if (outside_ff) begin
               div_dividend = win_ff;
               div_divisor  = win_lt_g ? 32'd1 : {24'd0, geff_ff};
            end else begin
               div_dividend = win_ff - {24'd0, geff_ff};
               div_divisor  = {24'd0, geff_ff};
            end
         end
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      dynamic_in = dynamic_ff;
      outside_in = outside_ff;
      base_in    = base_ff;
      max_in     = max_ff;
      gcfg_in    = gcfg_ff;
      seg_in     = seg_ff;
      round_in   = round_ff;
      group_in   = group_ff;
      serial_in  = serial_ff;
      active_in  = active_ff;
      window_in  = window_ff;
      full_in    = full_ff;
      geff_in    = geff_ff;
      win_in     = win_ff;
      fc_in      = fc_ff;
      n_in       = n_ff;
      clamp_in   = clamp_ff;
      tagged_in  = tagged_ff;
      ttype_in   = ttype_ff;
      tserial_in = tserial_ff;
      tround_in  = tround_ff;
      tgroup_in  = tgroup_ff;
      tgroups_in = tgroups_ff;
      rwin_in    = rwin_ff;
      rclamp_in  = rclamp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      grp_cur    = group_ff;
      grp_inc    = group_ff + 8'd1;

      if (csr_we) begin
         case (csr_index)
            CSR_DYNAMIC: dynamic_in = csr_wdata[0];
            CSR_OUTSIDE: outside_in = csr_wdata[0];
            CSR_BASE:    base_in    = csr_wdata;
            CSR_MAX:     max_in     = csr_wdata;
            CSR_GROUPS:  gcfg_in    = csr_wdata[7:0];
            CSR_SEGMENT: seg_in     = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // untagged defaults
               tagged_in  = 1'b0;
               ttype_in   = TAG_NONE;
               tserial_in = '0;
               tround_in  = '0;
               tgroup_in  = '0;
               tgroups_in = '0;
               rclamp_in  = 1'b0;
               case (req_kind)
                  KIND_WINDOW: begin
                     full_in  = 24'(base_ff) * 24'(g_eff);
                     geff_in  = g_eff;
                     clamp_in = 1'b0;
                  end
                  KIND_DATA: begin
                     if (base_ff != 16'd0) begin
                        // single group pins the index to zero
                        if (g_eff == 8'd1) grp_cur = 8'd0;
                        grp_inc    = grp_cur + 8'd1;
                        tagged_in  = 1'b1;
                        ttype_in   = seq_diff[31] ? TAG_RETX : TAG_NEW;
                        tserial_in = req_seq;
                        tround_in  = round_ff;
                        tgroup_in  = grp_cur;
                        tgroups_in = active_ff;
                        group_in   = grp_cur;
                        if (active_ff > 8'd1) begin
                           group_in = (grp_inc == active_ff) ? 8'd0 : grp_inc;
                        end
                        serial_in = req_seq + 32'd1;
                     end
                  end
                  KIND_REDUND: begin
                     tagged_in  = 1'b1;
                     ttype_in   = TAG_REDUND;
                     tserial_in = serial_ff;
                     tround_in  = round_ff;
                     tgroup_in  = group_ff;
                     tgroups_in = active_ff;
                     if (active_ff > 8'd1) begin
                        serial_in = serial_ff + 32'd1;
                        if (grp_inc == active_ff) begin
                           group_in = 8'd0;
                           round_in = round_ff + 32'd1;
                        end else begin
                           group_in = grp_inc;
                        end
                     end else if (active_ff == 8'd1) begin
                        group_in = 8'd0;
                        round_in = round_ff + 32'd1;
                     end
                  end
                  default: begin
                     round_in = round_ff + 32'd1;
                     group_in = 8'd0;
                  end
               endcase
               if (req_kind != KIND_WINDOW) begin
                  rwin_in      = window_ff;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_DIV1: begin
            if (div_stat.done) win_in = div_quotient;
         end
         ST_EVAL: begin
            if (!dynamic_ff) begin
               if (outside_ff || win_ge_edge) begin
                  window_in = {8'd0, full_ff};
                  active_in = geff_ff;
               end else begin
                  window_in = win_ff;
                  active_in = 8'd1;
               end
            end else if (outside_ff) begin
               n_in = win_lt_g ? 8'd1 : geff_ff;
            end else if (!win_ge_edge) begin
               window_in = win_ff;
               active_in = 8'd1;
            end else begin
               n_in = geff_ff;
            end
         end
         ST_DIV2: begin
            if (div_stat.done) fc_in = div_quotient;
         end
         ST_CLAMP: begin
            if (max_ff != 16'd0 && fc_ff >= {16'd0, max_ff}) begin
               fc_in    = {16'd0, max_ff};
               clamp_in = 1'b1;
            end
         end
         ST_MUL: begin
            window_in = 32'(fc_ff * {24'd0, n_ff});
            active_in = n_ff;
         end
         ST_DONE: begin
            if (out_free) begin
               tagged_in    = 1'b0;
               ttype_in     = TAG_NONE;
               tserial_in   = '0;
               tround_in    = '0;
               tgroup_in    = '0;
               tgroups_in   = '0;
               rwin_in      = window_ff;
               rclamp_in    = clamp_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      full_ff    <= full_in;
      geff_ff    <= geff_in;
      win_ff     <= win_in;
      fc_ff      <= fc_in;
      n_ff       <= n_in;
      clamp_ff   <= clamp_in;
      tagged_ff  <= tagged_in;
      ttype_ff   <= ttype_in;
      tserial_ff <= tserial_in;
      tround_ff  <= tround_in;
      tgroup_ff  <= tgroup_in;
      tgroups_ff <= tgroups_in;
      rwin_ff    <= rwin_in;
      rclamp_ff  <= rclamp_in;
      if (reset) begin
         dynamic_ff   <= 1'b0;
         outside_ff   <= 1'b0;
         base_ff      <= 16'd0;
         max_ff       <= 16'd0;
         gcfg_ff      <= 8'd1;
         seg_ff       <= 16'd1000;
         round_ff     <= 32'd1;
         group_ff     <= 8'd0;
         serial_ff    <= 32'd0;
         active_ff    <= 8'd0;
         window_ff    <= 32'd0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ST_IDLE;
      end else begin
         dynamic_ff   <= dynamic_in;
         outside_ff   <= outside_in;
         base_ff      <= base_in;
         max_ff       <= max_in;
         gcfg_ff      <= gcfg_in;
         seg_ff       <= seg_in;
         round_ff     <= round_in;
         group_ff     <= group_in;
         serial_ff    <= serial_in;
         active_ff    <= active_in;
         window_ff    <= window_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tagged_res = tagged_ff;
   assign rsp_tag_type   = ttype_ff;
   assign rsp_tag_serial = tserial_ff;
   assign rsp_tag_round  = tround_ff;
   assign rsp_tag_group  = tgroup_ff;
   assign rsp_tag_groups = tgroups_ff;
   assign rsp_fec_window = rwin_ff;
   assign rsp_clamp_hit  = rclamp_ff;

endmodule

FILE: sim/fec_sender_tagger_checker.sv
`timescale 1ns / 1ps
module fec_sender_tagger_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [1:0]                     req_kind,
   input  logic [31:0]                    req_cwnd_bytes,
   input  logic [31:0]                    req_seq,
   input  logic [31:0]                    req_high_tx_mark,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           rsp_tagged_res,
   input  logic [1:0]                     rsp_tag_type,
   input  logic [31:0]                    rsp_tag_serial,
   input  logic [31:0]                    rsp_tag_round,
   input  logic [7:0]                     rsp_tag_group,
   input  logic [7:0]                     rsp_tag_groups,
   input  logic [31:0]                    rsp_fec_window,
   input  logic                           rsp_clamp_hit,
   input  logic                           csr_we,
   input  logic [fst_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fst_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int unsigned                    fault_count,
   output int unsigned                    tags_owed
);
   import fst_pkg::*;

   typedef struct packed {
      logic        is_tag;
      logic [1:0]  ttype;
      logic [31:0] serial;
      logic [31:0] round;
      logic [7:0]  group;
      logic [7:0]  groups;
      logic [31:0] window;
      logic        clamp;
   } tag_word_type;

   // expected words in flight, oldest at the head
   tag_word_type due_word [16];
   logic [3:0]   due_head;
   logic [3:0]   due_tail;
   logic [4:0]   due_count;

   // register copies
   logic        cfg_dynamic;
   logic        cfg_outside;
   logic [15:0] cfg_base;
   logic [15:0] cfg_max;
   logic [7:0]  cfg_groups;
   logic [15:0] cfg_segment;

   // tagger state
   logic [31:0] round_no;
   logic [7:0]  group_no;
   logic [31:0] serial_no;
   logic [7:0]  live_groups;
   logic [31:0] window_pkts;

   function automatic logic [31:0] groups_in_use();
      return (cfg_groups == 8'd0) ? 32'd1 : {24'd0, cfg_groups};
   endfunction

   // cwnd in bytes -> packets, group count and FEC window; returns clamp flag
   function automatic logic resize_window(input logic [31:0] cwnd);
      logic [31:0] seg;
      logic [31:0] win;
      logic [31:0] g;
      logic [31:0] n;
      logic [31:0] fc;
      logic [63:0] full_pkts;
      logic [63:0] bound_pkts;
      logic        clamp;
      seg        = (cfg_segment == 16'd0) ? 32'd1 : {16'd0, cfg_segment};
      win        = cwnd / seg;
      g          = groups_in_use();
      full_pkts  = {48'd0, cfg_base} * {32'd0, g};
      bound_pkts = full_pkts + {32'd0, g};
      clamp      = 1'b0;
      if (!cfg_dynamic) begin
         if (cfg_outside || {32'd0, win} >= bound_pkts) begin
            window_pkts = full_pkts[31:0];
            live_groups = g[7:0];
         end else begin
            window_pkts = win;
            live_groups = 8'd1;
         end
      end else if (cfg_outside) begin
         n  = (win < g) ? 32'd1 : g;
         fc = win / n;
         if (cfg_max != 16'd0 && fc >= {16'd0, cfg_max}) begin
            fc    = {16'd0, cfg_max};
            clamp = 1'b1;
         end
         live_groups = n[7:0];
         window_pkts = fc * n;
      end else if ({32'd0, win} < bound_pkts) begin
         window_pkts = win;
         live_groups = 8'd1;
      end else begin
         fc = (win - g) / g;
         if (cfg_max != 16'd0 && fc >= {16'd0, cfg_max}) begin
            fc    = {16'd0, cfg_max};
            clamp = 1'b1;
         end
         window_pkts = fc * g;
         live_groups = g[7:0];
      end
      return clamp;
   endfunction

   function automatic tag_word_type tag_word(input logic [1:0] kind, input logic [31:0] cwnd,
                                             input logic [31:0] seq, input logic [31:0] hmark);
      tag_word_type t;
      logic [31:0]  lag;
      t = '0;
      case (kind)
         KIND_WINDOW: t.clamp = resize_window(cwnd);
         KIND_DATA: begin
            if (cfg_base != 16'd0) begin
               lag = seq - hmark;
               if (groups_in_use() == 32'd1)
                  group_no = 8'd0;
               t.is_tag = 1'b1;
               t.ttype  = lag[31] ? TAG_RETX : TAG_NEW;
               t.serial = seq;
               t.round  = round_no;
               t.group  = group_no;
               t.groups = live_groups;
               if (live_groups > 8'd1) begin
                  group_no = group_no + 8'd1;
                  if (group_no == live_groups)
                     group_no = 8'd0;
               end
               serial_no = seq + 32'd1;
            end
         end
         KIND_REDUND: begin
            t.is_tag = 1'b1;
            t.ttype  = TAG_REDUND;
            t.serial = serial_no;
            t.round  = round_no;
            t.group  = group_no;
            t.groups = live_groups;
            if (live_groups > 8'd1) begin
               group_no  = group_no + 8'd1;
               serial_no = serial_no + 32'd1;
               if (group_no == live_groups) begin
                  group_no = 8'd0;
                  round_no = round_no + 32'd1;
               end
            end else if (live_groups == 8'd1) begin
               group_no = 8'd0;
               round_no = round_no + 32'd1;
            end
         end
         default: begin
            round_no = round_no + 32'd1;
            group_no = 8'd0;
         end
      endcase
      t.window = window_pkts;
      return t;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h, got %h", $time, field, want, got);
         fault_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      tag_word_type want;
      if (reset) begin
         cfg_dynamic = 1'b0;
         cfg_outside = 1'b0;
         cfg_base    = 16'd0;
         cfg_max     = 16'd0;
         cfg_groups  = 8'd1;
         cfg_segment = 16'd1000;
         round_no    = 32'd1;
         group_no    = 8'd0;
         serial_no   = 32'd0;
         live_groups = 8'd0;
         window_pkts = 32'd0;
         due_head    = 4'd0;
         due_tail    = 4'd0;
         due_count   = 5'd0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_count == 5'd0) begin
               $display("%0t: response word expected none, got serial %h window %h",
                        $time, rsp_tag_serial, rsp_fec_window);
               fault_count++;
            end else begin
               want      = due_word[due_head];
               due_head  = due_head + 4'd1;
               due_count = due_count - 5'd1;
               check_field("tagged_res", want.is_tag, rsp_tagged_res);
               check_field("tag_type",   want.ttype,  rsp_tag_type);
               check_field("tag_serial", want.serial, rsp_tag_serial);
               check_field("tag_round",  want.round,  rsp_tag_round);
               check_field("tag_group",  want.group,  rsp_tag_group);
               check_field("tag_groups", want.groups, rsp_tag_groups);
               check_field("fec_window", want.window, rsp_fec_window);
               check_field("clamp_hit",  want.clamp,  rsp_clamp_hit);
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_DYNAMIC: cfg_dynamic = csr_wdata[0];
               CSR_OUTSIDE: cfg_outside = csr_wdata[0];
               CSR_BASE:    cfg_base    = csr_wdata;
               CSR_MAX:     cfg_max     = csr_wdata;
               CSR_GROUPS:  cfg_groups  = csr_wdata[7:0];
               CSR_SEGMENT: cfg_segment = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            due_word[due_tail] = tag_word(req_kind, req_cwnd_bytes, req_seq,
                                          req_high_tx_mark);
            due_tail  = due_tail + 4'd1;
            due_count = due_count + 5'd1;
         end
      end
      tags_owed = 32'(due_count);
   end

endmodule

FILE: sim/fec_sender_tagger_tb.sv
`timescale 1ns / 1ps
module fec_sender_tagger_tb;
   import fst_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   // request side
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_kind         = KIND_WINDOW;
   logic [31:0]           req_cwnd_bytes   = '0;
   logic [31:0]           req_seq          = '0;
   logic [31:0]           req_high_tx_mark = '0;

   // response side
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   logic                  rsp_tagged_res;
   logic [1:0]            rsp_tag_type;
   logic [31:0]           rsp_tag_serial;
   logic [31:0]           rsp_tag_round;
   logic [7:0]            rsp_tag_group;
   logic [7:0]            rsp_tag_groups;
   logic [31:0]           rsp_fec_window;
   logic                  rsp_clamp_hit;

   // register port
   logic                  csr_we           = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index        = CSR_DYNAMIC;
   logic [CSR_DATA_W-1:0] csr_wdata        = '0;

   int unsigned           fault_count;
   int unsigned           tags_owed;

   // sender burst bookkeeping
   int                    burst_left = 0;

   // receiver stall pattern
   logic [15:0]           stall_tick = '0;
   logic [1:0]            stall_mode = 2'd0;

   // last values loaded, used to aim cwnd at the interesting bounds
   logic [15:0]           reg_base   = 16'd0;
   logic [7:0]            reg_groups = 8'd1;
   logic [15:0]           reg_seg    = 16'd1000;

   // highest sequence sent so far; starts near the top so it wraps
   logic [31:0]           seq_run    = 32'hFFFF_FFC0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   fec_sender_tagger dut (.*);

   fec_sender_tagger_checker tag_check (.*);

   // Receiver: a new mode is drawn when the low byte of stall_tick is zero.
   // Mode 0 never stalls, mode 1 stalls at random, mode 2 takes one word in
   // eight, mode 3 stalls in blocks while bit 3 of stall_tick is set.
   always @(posedge clock) begin
      stall_tick <= stall_tick + 16'd1;
      if (stall_tick[7:0] == 8'd0)
         stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2'd2: rsp_ready <= (stall_tick[2:0] == 3'd0);
         default: rsp_ready <= ~stall_tick[3];
      endcase
   end

   // Hang guard: a run that has not finished by this delay reports errors.
   initial begin
      #5_000_000;
      $display("fec_sender_tagger_tb: done, errors");
      $finish;
   end

   // Present one word and hold it until taken. Valid only drops at the end
   // of a burst; a back-to-back word keeps valid high with no glitch.
   task automatic send_word(input logic [1:0] kind, input logic [31:0] cwnd,
                            input logic [31:0] seq, input logic [31:0] hmark);
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_cwnd_bytes   <= cwnd;
      req_seq          <= seq;
      req_high_tx_mark <= hmark;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(0, 30);
      end else begin
         burst_left--;
      end
   endtask

   // Sender off, then wait until every expected word has come back.
   // The first edge lets the checker book the last accepted word.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tags_owed != 0)
         @(posedge clock);
   endtask

   task automatic poke(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Registers only change with the block idle. csr_we drops once, after
   // the last write, so it never sees two assignments in one step.
   task automatic load_regs(input logic dyn, input logic outside, input logic [15:0] base,
                            input logic [15:0] max_win, input logic [7:0] groups,
                            input logic [15:0] seg);
      settle();
      poke(CSR_DYNAMIC, {15'd0, dyn});
      poke(CSR_OUTSIDE, {15'd0, outside});
      poke(CSR_BASE,    base);
      poke(CSR_MAX,     max_win);
      poke(CSR_GROUPS,  {8'd0, groups});
      poke(CSR_SEGMENT, seg);
      csr_we     <= 1'b0;
      reg_base   = base;
      reg_groups = groups;
      reg_seg    = seg;
   endtask

   // 16-bit register pick, weighted to the ends and to small values
   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 6))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2, 3:    return 16'($urandom_range(1, 8));
         4:       return 16'($urandom_range(9, 2000));
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      int          sent;
      int          phase_len;
      int          pick;
      logic [1:0]  kind;
      logic [31:0] cwnd;
      logic [31:0] seq;
      logic [31:0] hmark;
      logic [31:0] g_eff;
      logic [31:0] seg_eff;
      logic [31:0] span;
      logic [7:0]  groups;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // ---- directed words ----
      // Straight after reset: no active groups, so a redundancy word tags
      // and leaves the state alone; data is untagged while base is zero.
      send_word(KIND_REDUND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(KIND_DATA,   32'd0,         32'd1,         32'd0);
      send_word(KIND_RESET,  32'd0,         32'd0,         32'd0);
      send_word(KIND_WINDOW, 32'd0,         32'd0,         32'd0);
      send_word(KIND_DATA,   32'd5,         32'd9,         32'd3);

      // static inner, four groups of four, segment size zero (taken as one)
      load_regs(1'b0, 1'b0, 16'd4, 16'd0, 8'd4, 16'd0);
      send_word(KIND_WINDOW, 32'hFFFF_FFFF, 32'd0,         32'd0);
      send_word(KIND_DATA,   32'd0,         32'd0,         32'd0);
      // older than the high mark -> retransmitted, across the wrap too
      send_word(KIND_DATA,   32'd0,         32'hFFFF_FFFF, 32'd0);
      send_word(KIND_DATA,   32'd0,         32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_word(KIND_DATA,   32'd0,         32'd5,         32'd10);
      // redundancy runs the groups round and bumps the round
      repeat (4) send_word(KIND_REDUND, 32'd0, 32'd0, 32'd0);

      // dynamic inner with a small clamp, group count zero acts as one
      load_regs(1'b1, 1'b0, 16'd4, 16'd3, 8'd0, 16'd1);
      send_word(KIND_WINDOW, 32'd100,       32'd0,         32'd0);
      send_word(KIND_DATA,   32'd0,         32'd77,        32'd70);

      // dynamic outer, everything at its top value
      load_regs(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
      send_word(KIND_WINDOW, 32'd1000,      32'd0,         32'd0);
      send_word(KIND_WINDOW, 32'hFFFF_FFFF, 32'd0,         32'd0);
      repeat (3) send_word(KIND_DATA, 32'd0, 32'($urandom), 32'($urandom));

      // shrink to two groups while the group index sits above that:
      // the index has to count on until it wraps
      load_regs(1'b0, 1'b1, 16'd1, 16'd1, 8'd2, 16'd1);
      send_word(KIND_WINDOW, 32'd7,         32'd0,         32'd0);
      repeat (2) send_word(KIND_REDUND, 32'd0, 32'd0, 32'd0);
      send_word(KIND_RESET,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      // ---- random phases ----
      // Each phase loads a fresh setting, then a run of words: mostly data
      // and redundancy in sequence order, with some window updates, retx,
      // stray sequence numbers and round resets mixed in.
      sent = 0;
      while (sent < 650) begin
         groups = ($urandom_range(0, 9) == 0) ? 8'd0 :
                  ($urandom_range(0, 4) == 0) ? 8'hFF :
                  ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 8)) : 8'($urandom);
         load_regs(1'($urandom), 1'($urandom), pick16(), pick16(), groups,
                   ($urandom_range(0, 9) == 0) ? 16'd0 : pick16());
         g_eff     = (reg_groups == 8'd0) ? 32'd1 : {24'd0, reg_groups};
         seg_eff   = (reg_seg == 16'd0) ? 32'd1 : {16'd0, reg_seg};
         span      = ({16'd0, reg_base} + 32'd1) * g_eff * 32'd3;
         phase_len = $urandom_range(10, 60);
         repeat (phase_len) begin
            pick  = $urandom_range(0, 99);
            cwnd  = $urandom;
            seq   = $urandom;
            hmark = $urandom;
            if (pick < 14) begin
               kind = KIND_WINDOW;
               case ($urandom_range(0, 5))
                  0: cwnd = $urandom;
                  1: cwnd = $urandom_range(0, 4000);
                  2: cwnd = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
                  default: cwnd = seg_eff * $urandom_range(0, span) +
                                  $urandom_range(0, seg_eff - 1);
               endcase
            end else if (pick < 60) begin
               kind = KIND_DATA;
               case ($urandom_range(0, 9))
                  6, 7: begin
                     seq   = seq_run - $urandom_range(1, 64);
                     hmark = seq_run;
                  end
                  8: ;
                  9: begin
                     seq   = seq_run;
                     hmark = seq_run;
                  end
                  default: begin
                     hmark   = seq_run;
                     seq_run = seq_run + 32'd1;
                     seq     = seq_run;
                  end
               endcase
            end else if (pick < 95) begin
               kind = KIND_REDUND;
            end else begin
               kind = KIND_RESET;
            end
            send_word(kind, cwnd, seq, hmark);
            sent++;
         end
      end

      // drain, then allow for the slowest window update
      settle();
      repeat (80) @(posedge clock);
      if (fault_count == 0 && tags_owed == 0)
         $display("fec_sender_tagger_tb: done, clean");
      else
         $display("fec_sender_tagger_tb: done, errors");
      $finish;
   end

endmodule
